// ===== rtl/core/sstq_pkg.sv =====
// Shared types, constants and helpers for the sorted sleep timer queue.
// Used by the queue cell and by the top level; depends on nothing.
package sstq_pkg;

	localparam int MAX_TASKS = 16;
	localparam int TICK_BITS = 32;
	localparam int ID_BITS   = 4;
	localparam int CNT_BITS  = $clog2(MAX_TASKS + 1);

	// Input operation codes.
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_SLEEP = 1'b1;

	// Result kind codes.
	localparam logic KIND_SLEEP = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	// Answer to a sleep request.
	typedef enum logic [1:0] {
		ST_ACCEPTED = 2'd0,
		ST_IGNORED  = 2'd1,
		ST_SLEEPING = 2'd2
	} status_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_SLEEP,
		S_TICK
	} state_t;

	// One queue slot as it moves between neighboring cells.
	typedef struct packed {
		logic                 valid;
		logic [ID_BITS-1:0]   task_id;
		logic [TICK_BITS-1:0] wake;
	} entry_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic insert;
		logic pop;
	} cell_cmd_t;

	// A wake tick is due once the wrap-aware difference is zero or positive.
	function automatic logic is_due(input logic [TICK_BITS-1:0] now,
		input logic [TICK_BITS-1:0] wake);
		logic [TICK_BITS-1:0] diff;
		diff = now - wake;
		return ~diff[TICK_BITS-1];
	endfunction

endpackage

// ===== rtl/core/sorted_sleep_timer_queue.sv =====
// Sorted sleep timer queue: tick counter plus a chain of cells kept sorted by wake tick.
// A sleep item is worked in S_SLEEP; a tick item stays in S_TICK while the head and the next entry are both due.
// Each result is registered and shows in the cycle after its cycle of work, for one cycle only;
// the receiver cannot stall, and no new item is accepted while busy.
// The chain inserts or pops one entry per cycle.
// Reset clears the counter, the fill count and every cell's valid flag at once.
module sorted_sleep_timer_queue (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           op,
	input  logic [sstq_pkg::ID_BITS-1:0]   task_id,
	input  logic                           is_running,
	input  logic [sstq_pkg::TICK_BITS-1:0] sleep_ticks,
	output logic                           result_valid,
	output logic                           kind,
	output logic [1:0]                     status,
	output logic                           woken_valid,
	output logic [sstq_pkg::ID_BITS-1:0]   woken_task,
	output logic                           last
);

	localparam int N = sstq_pkg::MAX_TASKS;

	sstq_pkg::state_t  state_q, state_d;
	logic [sstq_pkg::TICK_BITS-1:0] tick_q;
	logic [sstq_pkg::CNT_BITS-1:0]  count_q, count_d;

	logic [sstq_pkg::ID_BITS-1:0]   req_task_q;
	logic                           req_ok_q;
	logic [sstq_pkg::TICK_BITS-1:0] req_wake_q;

	sstq_pkg::cell_cmd_t cmd;
	sstq_pkg::entry_t    cell_ent [N];
	logic [N-1:0]        cell_shift;
	logic [N-1:0]        cell_match;
	logic [N-1:0]        cell_valid;
	logic                accept;
	logic                full;
	logic                head_due;
	logic                next_due;

	logic                       res_valid_d, res_kind_d, res_woken_d, res_last_d;
	sstq_pkg::status_t          res_status_d;
	logic [sstq_pkg::ID_BITS-1:0] res_task_d;

	assign busy     = (state_q != sstq_pkg::S_IDLE);
	assign accept   = start && !busy;
	assign full     = (count_q == sstq_pkg::CNT_BITS'(N));
	assign head_due = cell_ent[0].valid && sstq_pkg::is_due(tick_q, cell_ent[0].wake);
	assign next_due = cell_ent[1].valid && sstq_pkg::is_due(tick_q, cell_ent[1].wake);

	// Chain of cells; the first sees an always-valid left neighbor, the last an empty right one.
	for (genvar i = 0; i < N; i++) begin : g_cell
		sstq_pkg::entry_t left_ent;
		sstq_pkg::entry_t right_ent;
		logic             left_sh;

		if (i == 0) begin : g_first
			assign left_ent = '{valid: 1'b1, task_id: '0, wake: '0};
			assign left_sh  = 1'b0;
		end else begin : g_mid
			assign left_ent = cell_ent[i-1];
			assign left_sh  = cell_shift[i-1];
		end
		if (i == N - 1) begin : g_last
			assign right_ent = '{valid: 1'b0, task_id: '0, wake: '0};
		end else begin : g_inner
			assign right_ent = cell_ent[i+1];
		end

		sstq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.new_task   (req_task_q),
			.new_wake   (req_wake_q),
			.left       (left_ent),
			.left_shift (left_sh),
			.right      (right_ent),
			.ent        (cell_ent[i]),
			.shift_out  (cell_shift[i]),
			.match      (cell_match[i])
		);
		assign cell_valid[i] = cell_ent[i].valid;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			sstq_pkg::S_IDLE: begin
				if (accept) begin
					state_d = (op == sstq_pkg::OP_SLEEP) ? sstq_pkg::S_SLEEP : sstq_pkg::S_TICK;
				end
			end
			sstq_pkg::S_SLEEP: state_d = sstq_pkg::S_IDLE;
			sstq_pkg::S_TICK: begin
				if (!head_due || !next_due) begin
					state_d = sstq_pkg::S_IDLE;
				end
			end
			default: state_d = sstq_pkg::S_IDLE;
		endcase
	end

	// Cell commands, fill count and the result of this cycle of work.
	always_comb begin
		cmd          = '0;
		count_d      = count_q;
		res_valid_d  = 1'b0;
		res_kind_d   = sstq_pkg::KIND_SLEEP;
		res_status_d = sstq_pkg::ST_ACCEPTED;
		res_woken_d  = 1'b0;
		res_task_d   = '0;
		res_last_d   = 1'b1;
		case (state_q)
			sstq_pkg::S_SLEEP: begin
				res_valid_d = 1'b1;
				if (!req_ok_q) begin
					res_status_d = sstq_pkg::ST_IGNORED;
				end else if (|cell_match) begin
					res_status_d = sstq_pkg::ST_SLEEPING;
				end else if (full) begin
					res_status_d = sstq_pkg::ST_IGNORED;
				end else begin
					cmd.insert = 1'b1;
					count_d    = count_q + 1'b1;
				end
			end
			sstq_pkg::S_TICK: begin
				res_valid_d = 1'b1;
				res_kind_d  = sstq_pkg::KIND_TICK;
				if (head_due) begin
					cmd.pop     = 1'b1;
					count_d     = count_q - 1'b1;
					res_woken_d = 1'b1;
					res_task_d  = cell_ent[0].task_id;
					res_last_d  = !next_due;
				end
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sstq_pkg::S_IDLE;
			tick_q       <= '0;
			count_q      <= '0;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			count_q      <= count_d;
			result_valid <= res_valid_d;
			if (accept && op == sstq_pkg::OP_TICK) begin
				tick_q <= tick_q + 1'b1;
			end
		end
	end

	// Captured request and registered result payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_task_q <= task_id;
			req_ok_q   <= is_running && (sleep_ticks != '0);
			req_wake_q <= tick_q + sleep_ticks;
		end
		kind        <= res_kind_d;
		status      <= res_status_d;
		woken_valid <= res_woken_d;
		woken_task  <= res_task_d;
		last        <= res_last_d;
	end

	// The fill count tracks the valid cells and never passes the chain length.
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == sstq_pkg::CNT_BITS'($countones(cell_valid)))
		else $error("fill count differs from valid cells");

	// Only a tick that wakes a task can be followed by more results.
	a_not_last_is_wake: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> kind == sstq_pkg::KIND_TICK && woken_valid)
		else $error("non-final result without a woken task");

	// An accepted item always produces a result, after its work state and the result register.
	a_item_answered: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 result_valid)
		else $error("accepted item gave no result");

	// The head of the queue is never behind its successor.
	a_sorted_head: assert property (@(posedge clk) disable iff (!arst_n)
		cell_ent[1].valid |-> cell_ent[0].valid && cell_ent[0].wake <= cell_ent[1].wake)
		else $error("queue head out of order");

endmodule

// ===== rtl/core/sstq_cell.sv =====
// One slot of the sorted queue chain: holds an entry and trades it with its neighbors.
// Depends on sstq_pkg for the entry and command types.
module sstq_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sstq_pkg::cell_cmd_t           cmd,
	input  logic [sstq_pkg::ID_BITS-1:0]  new_task,
	input  logic [sstq_pkg::TICK_BITS-1:0] new_wake,
	input  sstq_pkg::entry_t              left,
	input  logic                          left_shift,
	input  sstq_pkg::entry_t              right,
	output sstq_pkg::entry_t              ent,
	output logic                          shift_out,
	output logic                          match
);

	logic                           valid_q;
	logic [sstq_pkg::ID_BITS-1:0]   task_q;
	logic [sstq_pkg::TICK_BITS-1:0] wake_q;
	sstq_pkg::entry_t               cur;
	sstq_pkg::entry_t               ent_d;
	logic                           later;

	assign cur = '{valid: valid_q, task_id: task_q, wake: wake_q};

	// This entry wakes strictly after the new one, so it moves one slot right.
	assign later     = cur.valid && (cur.wake > new_wake);
	assign shift_out = later;
	assign match     = cur.valid && (cur.task_id == new_task);
	assign ent       = cur;

	// Next contents: shift right on insert, take the new entry at the slot, shift left on pop.
	always_comb begin
		ent_d = cur;
		if (cmd.insert) begin
			if (left_shift) begin
				ent_d = left;
			end else if (left.valid && (!cur.valid || later)) begin
				ent_d.valid   = 1'b1;
				ent_d.task_id = new_task;
				ent_d.wake    = new_wake;
			end
		end else if (cmd.pop) begin
			ent_d = right;
		end
	end

	// The valid flag is control state and is cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= ent_d.valid;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		task_q <= ent_d.task_id;
		wake_q <= ent_d.wake;
	end

endmodule
